>>> src/rto_pkg.sv
// rto_pkg: shared constants, types and table helper for the retriggerable
// triangle oscillator; no dependencies
package rto_pkg;

  localparam int PHASE_FRAC_BITS_DEF = 20;
  localparam int LEVEL_FRAC_BITS_DEF = 14;

  // input request: trigger in bit 0, deg_size above it, padded to bytes
  localparam int DEG_W  = 17;
  localparam int IN_W   = 24;

  localparam logic [DEG_W-1:0] DEG_MAX = 17'd92160;

  // 92160 = 45 * 2^11, so the step is deg/45 scaled by 2^(frac bits - 11)
  localparam int DEG_POW2_SHIFT = 11;
  localparam int DIV_45         = 45;
  localparam int RECIP_45       = 46603;   // floor(2^21 / 45)
  localparam int RECIP_SHIFT    = 21;
  localparam int RECIP_W        = 16;
  localparam int MUL_W          = DEG_W + RECIP_W;
  localparam int Q_W            = 12;
  localparam int R_W            = 6;
  localparam int REM_W          = 7;
  localparam int TAB_N          = 64;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RECYCLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO    = 1'b1;

  typedef logic [2:0] sec_t;

  localparam sec_t SEC_RISE   = 3'd0;
  localparam sec_t SEC_FALL   = 3'd1;
  localparam sec_t SEC_DIP    = 3'd2;
  localparam sec_t SEC_RETURN = 3'd3;
  localparam sec_t SEC_DONE   = 3'd4;

  // floor(r * 2^sh / 45), evaluated at elaboration only
  function automatic longint frac_entry(input int unsigned r, input int unsigned sh);
    longint num;
    num = longint'(r) << sh;
    return num / DIV_45;
  endfunction

endpackage

>>> src/retriggerable_triangle_oscillator.sv
// Retriggerable triangle oscillator: one result per request, one request per cycle
// while the output is not stalled. Each result passes the input register, step divide
// register, step register, then output register.
// Throughput: one request per cycle while output is not stalled, set by the state loop
// and its span-times-phase multiply; stages move up into bubbles while output stalls.
// Reset (rst, synchronous) clears configuration, wave state and all valid flags.
// Depends on rto_pkg.
module retriggerable_triangle_oscillator #(
  parameter int PHASE_FRAC_BITS = rto_pkg::PHASE_FRAC_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = rto_pkg::LEVEL_FRAC_BITS_DEF,
  localparam int LW    = LEVEL_FRAC_BITS + 3,
  localparam int OUT_W = ((LW + 1 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rto_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rto_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rto_pkg::IN_W-1:0]        s_tdata,   // trigger, deg_size
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_W-1:0]                m_tdata    // level, playing
);

  localparam int PF      = PHASE_FRAC_BITS;
  localparam int PW      = PF + 3;
  localparam int SW      = PF + 1;
  localparam int STEP_SH = PF - rto_pkg::DEG_POW2_SHIFT;
  localparam int PRW     = LW + PW;

  localparam logic signed [PW:0]   ONE_P_X  = {3'b000, 1'b1, {PF{1'b0}}};
  localparam logic signed [PW-1:0] ONE_P    = {2'b00, 1'b1, {PF{1'b0}}};
  localparam logic signed [PW-1:0] PH_MIN   = {3'b100, {PF{1'b0}}};
  localparam logic signed [PW-1:0] PH_MAX   = {3'b011, {PF{1'b1}}};
  localparam logic signed [PW:0]   PH_MIN_X = {4'b1100, {PF{1'b0}}};
  localparam logic signed [PW:0]   PH_MAX_X = {4'b0011, {PF{1'b1}}};
  localparam logic signed [PRW:0]  HALF_P   = {{(PRW - PF + 1){1'b0}}, 1'b1, {(PF-1){1'b0}}};

  localparam logic signed [LW-1:0] ONE_L    = {2'b00, 1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic signed [LW-1:0] NEG_ONE_L = -ONE_L;
  localparam logic signed [LW-1:0] LV_MIN   = {3'b100, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic signed [LW-1:0] LV_MAX   = {3'b011, {LEVEL_FRAC_BITS{1'b1}}};
  localparam logic signed [LW:0]   ONE_L_X  = {3'b000, 1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic signed [LW:0]   LV_MAX_X = {4'b0011, {LEVEL_FRAC_BITS{1'b1}}};
  localparam logic signed [LW+3:0] LV_MAX_W = {7'b0000011, {LEVEL_FRAC_BITS{1'b1}}};
  localparam logic signed [LW+3:0] LV_MIN_W = {7'b1111100, {LEVEL_FRAC_BITS{1'b0}}};

  // configuration
  logic recycle_enable;
  logic zero_on_retrigger;

  // pipeline valid flags and moves
  logic va, vb, vc;
  logic can_o, can_c, can_b, can_a;
  logic s_acc, move_ab, move_bc, move_co;

  // stage a: accepted request
  logic                      a_trig;
  logic [rto_pkg::DEG_W-1:0] a_deg;
  logic [rto_pkg::DEG_W-1:0] a_degc;
  logic [rto_pkg::MUL_W-1:0] a_mul;

  // stage b: clamped deg and estimated quotient
  logic                      b_trig;
  logic [rto_pkg::DEG_W-1:0] b_deg;
  logic [rto_pkg::Q_W-1:0]   b_q0;
  logic [rto_pkg::DEG_W-1:0] b_m45;
  logic [rto_pkg::DEG_W-1:0] b_diff;
  logic [rto_pkg::REM_W-1:0] b_r0;
  logic [rto_pkg::Q_W-1:0]   b_q;
  logic [rto_pkg::R_W-1:0]   b_r;
  logic [SW-1:0]             b_step;
  logic [STEP_SH-1:0]        frac_tab [rto_pkg::TAB_N];

  // stage c: phase step
  logic          c_trig;
  logic [SW-1:0] c_step;

  // wave state
  logic                  play;
  rto_pkg::sec_t         sec;
  logic signed [PW-1:0]  frac;
  logic signed [LW-1:0]  start;
  logic signed [LW-1:0]  span;
  logic signed [LW-1:0]  held;

  logic                  play_next;
  rto_pkg::sec_t         sec_next;
  logic signed [PW-1:0]  frac_next;
  logic signed [LW-1:0]  start_next;
  logic signed [LW-1:0]  span_next;
  logic signed [LW-1:0]  held_next;

  // update datapath
  logic signed [PW:0]    f_dec;
  logic signed [PW-1:0]  f1;
  logic signed [LW-1:0]  h1, st1, sp1;
  logic signed [PRW-1:0] prod;
  logic signed [PRW:0]   rnd;
  logic signed [PRW:0]   rnd_sh;
  logic signed [LW+2:0]  delta;
  logic signed [LW+3:0]  lvl;
  logic signed [LW-1:0]  h2;
  logic signed [PW:0]    f_add;
  logic signed [PW-1:0]  f_sat;
  rto_pkg::sec_t         sec_inc;

  function automatic logic signed [LW-1:0] span_of(input logic signed [LW-1:0] h);
    logic signed [LW:0] d;
    d = ONE_L_X - {h[LW-1], h};
    return (d > LV_MAX_X) ? LV_MAX : d[LW-1:0];
  endfunction

  // handshake: each stage moves on when the next one is empty or moving
  assign can_o    = !m_tvalid || m_tready;
  assign can_c    = !vc || can_o;
  assign can_b    = !vb || can_c;
  assign can_a    = !va || can_b;
  assign s_tready = can_a;
  assign s_acc    = s_tvalid && can_a;
  assign move_ab  = va && can_b;
  assign move_bc  = vb && can_c;
  assign move_co  = vc && can_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      va       <= s_acc || (va && !can_b);
      vb       <= move_ab || (vb && !can_c);
      vc       <= move_bc || (vc && !can_o);
      m_tvalid <= move_co || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recycle_enable    <= 1'b0;
      zero_on_retrigger <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rto_pkg::REG_RECYCLE: recycle_enable    <= cfg_data[0];
        rto_pkg::REG_ZERO:    zero_on_retrigger <= cfg_data[0];
      endcase
    end
  end

  // stage a: clamp and reciprocal multiply for deg / 45
  assign a_degc = (a_deg > rto_pkg::DEG_MAX) ? rto_pkg::DEG_MAX : a_deg;
  assign a_mul  = rto_pkg::MUL_W'(a_degc) * rto_pkg::MUL_W'(rto_pkg::RECIP_45);

  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_trig <= s_tdata[0];
      a_deg  <= s_tdata[rto_pkg::DEG_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_trig <= a_trig;
      b_deg  <= a_degc;
      b_q0   <= a_mul[rto_pkg::RECIP_SHIFT +: rto_pkg::Q_W];
    end
  end

  // stage b: quotient correction, remainder table, step assembly
  for (genvar gi = 0; gi < rto_pkg::TAB_N; gi++) begin : g_tab
    assign frac_tab[gi] = STEP_SH'(rto_pkg::frac_entry(gi, STEP_SH));
  end

  assign b_m45  = rto_pkg::DEG_W'(b_q0) * rto_pkg::DEG_W'(rto_pkg::DIV_45);
  assign b_diff = b_deg - b_m45;
  assign b_r0   = b_diff[rto_pkg::REM_W-1:0];

  always_comb begin
    if (b_r0 >= rto_pkg::REM_W'(rto_pkg::DIV_45)) begin
      b_q = b_q0 + rto_pkg::Q_W'(1);
      b_r = rto_pkg::R_W'(b_r0 - rto_pkg::REM_W'(rto_pkg::DIV_45));
    end else begin
      b_q = b_q0;
      b_r = b_r0[rto_pkg::R_W-1:0];
    end
    b_step = (SW'(b_q) << STEP_SH) + SW'(frac_tab[b_r]);
  end

  always_ff @(posedge clk) begin
    if (move_bc) begin
      c_trig <= b_trig;
      c_step <= b_step;
    end
  end

  // state update: trigger, level from current phase, then phase step
  assign prod   = sp1 * f1;
  assign rnd    = {prod[PRW-1], prod} + HALF_P;
  assign rnd_sh = rnd >>> PF;
  assign delta  = rnd_sh[LW+2:0];
  assign lvl    = {{4{st1[LW-1]}}, st1} + {delta[LW+2], delta};
  assign f_add  = {f1[PW-1], f1} + {3'b000, c_step};
  assign sec_inc = sec + 3'd1;

  always_comb begin
    f_dec = {frac[PW-1], frac} - ONE_P_X;
    if (c_trig) begin
      f1  = (f_dec < PH_MIN_X) ? PH_MIN : f_dec[PW-1:0];
      h1  = zero_on_retrigger ? '0 : held;
      st1 = h1;
      sp1 = span_of(h1);
    end else begin
      f1  = frac;
      h1  = held;
      st1 = start;
      sp1 = span;
    end

    if (lvl > LV_MAX_W) begin
      h2 = LV_MAX;
    end else if (lvl < LV_MIN_W) begin
      h2 = LV_MIN;
    end else begin
      h2 = lvl[LW-1:0];
    end
    f_sat = (f_add > PH_MAX_X) ? PH_MAX : f_add[PW-1:0];

    play_next  = play || c_trig;
    sec_next   = c_trig ? rto_pkg::SEC_RISE : sec;
    frac_next  = f1;
    start_next = st1;
    span_next  = sp1;
    held_next  = h1;

    if (play_next) begin
      held_next = h2;
      frac_next = f_sat;
      if (f_sat >= ONE_P) begin
        frac_next = f_sat - ONE_P;
        sec_next  = c_trig ? rto_pkg::SEC_FALL : sec_inc;
        unique case (sec_next)
          rto_pkg::SEC_FALL: begin
            start_next = ONE_L;
            span_next  = NEG_ONE_L;
          end
          rto_pkg::SEC_DIP: begin
            start_next = '0;
            span_next  = NEG_ONE_L;
          end
          rto_pkg::SEC_RETURN: begin
            start_next = NEG_ONE_L;
            span_next  = ONE_L;
          end
          default: begin
            if (recycle_enable) begin
              sec_next   = rto_pkg::SEC_RISE;
              held_next  = zero_on_retrigger ? '0 : h2;
              start_next = held_next;
              span_next  = span_of(held_next);
            end else begin
              play_next = 1'b0;
              sec_next  = rto_pkg::SEC_DONE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play  <= 1'b0;
      sec   <= rto_pkg::SEC_RISE;
      frac  <= '0;
      start <= '0;
      span  <= '0;
      held  <= '0;
    end else if (move_co) begin
      play  <= play_next;
      sec   <= sec_next;
      frac  <= frac_next;
      start <= start_next;
      span  <= span_next;
      held  <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move_co) begin
      m_tdata <= OUT_W'({play_next, held_next});
    end
  end

`ifndef NO_ASSERTIONS
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    sec <= rto_pkg::SEC_DONE)
    else $error("section index out of range");

  a_idle_sec: assert property (@(posedge clk) disable iff (rst)
    !play |-> (sec == rto_pkg::SEC_RISE || sec == rto_pkg::SEC_DONE))
    else $error("stopped wave with section in progress");

  a_frac_below_one: assert property (@(posedge clk) disable iff (rst)
    frac < ONE_P)
    else $error("phase fraction left unwrapped");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !move_co |=> $stable(held) && $stable(play) && $stable(frac))
    else $error("wave state changed without a request");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (va && vb && vc && m_tvalid))
    else $error("request refused with a free stage");
`endif

endmodule

>>> test/tb.sv
// tb: self-checking testbench for retriggerable_triangle_oscillator; drives requests on the
// input stream, predicts each wave sample in fixed point and checks the output stream
// depends on rto_pkg and retriggerable_triangle_oscillator
module tb;
  import rto_pkg::*;

  localparam int PF = PHASE_FRAC_BITS_DEF;
  localparam int LF = LEVEL_FRAC_BITS_DEF;
  localparam int LW = LF + 3;
  localparam int OUT_W = ((LW + 1 + 7) / 8) * 8;

  localparam longint ONE_P  = longint'(1) << PF;
  localparam longint PH_MIN = -(longint'(1) << (PF + 2));
  localparam longint PH_MAX = (longint'(1) << (PF + 2)) - 1;
  localparam longint ONE_L  = longint'(1) << LF;
  localparam longint LV_MIN = -(longint'(1) << (LF + 2));
  localparam longint LV_MAX = (longint'(1) << (LF + 2)) - 1;

  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 6;
  localparam int PHASE_REQS = 140;

  typedef struct packed {
    logic [LW-1:0] level;
    logic          playing;
  } wave_sample_t;

  typedef struct packed {
    bit               trig;
    logic [DEG_W-1:0] deg;
    bit               typed;
    logic [LW-1:0]    lvl;
    bit               play;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;

  retriggerable_triangle_oscillator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // wave state and settings as the block should hold them
  bit                   recycle_on;
  bit                   zero_on;
  bit                   wave_playing;
  sec_t                 wave_sec;
  logic signed [PF+2:0] wave_phase;
  logic signed [LW-1:0] sec_start;
  logic signed [LW-1:0] sec_span;
  logic signed [LW-1:0] held_level;

  wave_sample_t pending_samples[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           row_typed = 1'b0;
  wave_sample_t row_sample = '0;
  stim_row_t    dir_rows [0:N_DIRECTED-1];

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic restart_rise();
    wave_sec = SEC_RISE;
    if (zero_on)
      held_level = '0;
    sec_start = held_level;
    sec_span = LW'(sat(ONE_L - longint'(sec_start), LV_MIN, LV_MAX));
  endtask

  task automatic step_triangle(input bit trig, input logic [DEG_W-1:0] deg,
                               output wave_sample_t res);
    logic [DEG_W-1:0] d;
    longint step;
    longint ph;
    longint prod;
    longint lv;
    d = (deg > DEG_MAX) ? DEG_MAX : deg;
    step = (longint'(d) << PF) / longint'(DEG_MAX);
    if (trig) begin
      wave_playing = 1'b1;
      wave_phase = (PF+3)'(sat(longint'(wave_phase) - ONE_P, PH_MIN, PH_MAX));
      restart_rise();
    end
    if (wave_playing) begin
      prod = longint'(sec_span) * longint'(wave_phase);
      lv = longint'(sec_start) + ((prod + ONE_P / 2) >>> PF);
      held_level = LW'(sat(lv, LV_MIN, LV_MAX));
      ph = sat(longint'(wave_phase) + step, PH_MIN, PH_MAX);
      if (ph >= ONE_P) begin
        ph = ph - ONE_P;
        wave_sec = wave_sec + 3'd1;
        case (wave_sec)
          SEC_FALL: begin
            sec_start = LW'(ONE_L);
            sec_span = LW'(-ONE_L);
          end
          SEC_DIP: begin
            sec_start = '0;
            sec_span = LW'(-ONE_L);
          end
          SEC_RETURN: begin
            sec_start = LW'(-ONE_L);
            sec_span = LW'(ONE_L);
          end
          default: begin
            if (recycle_on) begin
              restart_rise();
            end else begin
              wave_playing = 1'b0;
              wave_sec = SEC_DONE;
            end
          end
        endcase
      end
      wave_phase = (PF+3)'(ph);
    end
    res.level = held_level;
    res.playing = wave_playing;
  endtask

  always @(negedge clk) begin
    m_tready <= (recv_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_samples
    wave_sample_t res;
    wave_sample_t want;
    wave_sample_t got;
    if (!rst && s_tvalid && s_tready) begin
      step_triangle(s_tdata[0], s_tdata[DEG_W:1], res);
      pending_samples.push_back(row_typed ? row_sample : res);
    end
    if (!rst && m_tvalid && m_tready) begin
      got.level = m_tdata[LW-1:0];
      got.playing = m_tdata[LW];
      if (pending_samples.size() == 0) begin
        $error("sample with no request waiting: level %0d playing %0b",
               $signed(got.level), got.playing);
        fail_count++;
      end else begin
        want = pending_samples.pop_front();
        if (got.level !== want.level) begin
          $error("level mismatch: expected %0d, actual %0d",
                 $signed(want.level), $signed(got.level));
          fail_count++;
        end
        if (got.playing !== want.playing) begin
          $error("playing mismatch: expected %0b, actual %0b", want.playing, got.playing);
          fail_count++;
        end
      end
    end
  end

  task automatic drive_req(input bit trig, input logic [DEG_W-1:0] deg,
                           input bit typed, input wave_sample_t sample);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W - DEG_W - 1){1'b0}}, deg, trig};
    row_typed = typed;
    row_sample = sample;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_samples.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input bit rec, input bit zero);
    cfg_we <= 1'b1;
    cfg_index <= REG_RECYCLE;
    cfg_data <= rec;
    @(negedge clk);
    cfg_index <= REG_ZERO;
    cfg_data <= zero;
    @(negedge clk);
    cfg_we <= 1'b0;
    recycle_on = rec;
    zero_on = zero;
  endtask

  task automatic drive_random();
    int r;
    logic [DEG_W-1:0] deg;
    bit trig;
    r = $urandom_range(99);
    if (r < 8)
      deg = '0;
    else if (r < 16)
      deg = DEG_MAX;
    else if (r < 24)
      deg = DEG_W'($urandom_range(131071, 92161));
    else if (r < 40)
      deg = DEG_W'($urandom_range(131071));
    else
      deg = DEG_W'($urandom_range(92160, 4096));
    trig = wave_playing ? ($urandom_range(99) < 4) : ($urandom_range(99) < 35);
    drive_req(trig, deg, 1'b0, '0);
  endtask

  initial begin
    bit rec_set [0:N_PHASES-1];
    bit zero_set [0:N_PHASES-1];
    int mode;
    rec_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    zero_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    dir_rows = '{
      '{1'b0, 17'd92160,  1'b1, 17'd0,       1'b0},
      '{1'b0, 17'd131071, 1'b1, 17'd0,       1'b0},
      '{1'b1, 17'd0,      1'b1, -17'sd16384, 1'b1},
      '{1'b0, 17'd0,      1'b1, -17'sd16384, 1'b1},
      '{1'b0, 17'd92160,  1'b1, -17'sd16384, 1'b1},
      '{1'b0, 17'd92160,  1'b1, 17'd0,       1'b1},
      '{1'b0, 17'd92160,  1'b1, 17'd16384,   1'b1},
      '{1'b0, 17'd92160,  1'b1, 17'd0,       1'b1},
      '{1'b0, 17'd92160,  1'b1, -17'sd16384, 1'b0},
      '{1'b0, 17'd46080,  1'b0, 17'd0,       1'b0},
      '{1'b1, 17'd0,      1'b0, 17'd0,       1'b0},
      '{1'b1, 17'd0,      1'b0, 17'd0,       1'b0},
      '{1'b1, 17'd0,      1'b0, 17'd0,       1'b0},
      '{1'b1, 17'd0,      1'b0, 17'd0,       1'b0},
      '{1'b1, 17'd0,      1'b0, 17'd0,       1'b0},
      '{1'b0, 17'd131071, 1'b0, 17'd0,       1'b0},
      '{1'b0, 17'd1,      1'b0, 17'd0,       1'b0},
      '{1'b0, 17'd92159,  1'b0, 17'd0,       1'b0},
      '{1'b0, 17'd65536,  1'b0, 17'd0,       1'b0},
      '{1'b1, 17'd65535,  1'b0, 17'd0,       1'b0},
      '{1'b0, 17'd92160,  1'b0, 17'd0,       1'b0},
      '{1'b0, 17'd92160,  1'b0, 17'd0,       1'b0}
    };
    recycle_on = 1'b0;
    zero_on = 1'b0;
    wave_playing = 1'b0;
    wave_sec = SEC_RISE;
    wave_phase = '0;
    sec_start = '0;
    sec_span = '0;
    held_level = '0;
    send_idle_pct = 34;
    recv_idle_pct = 59;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      drive_req(dir_rows[i].trig, dir_rows[i].deg, dir_rows[i].typed,
                '{dir_rows[i].lvl, dir_rows[i].play});

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      set_config(rec_set[p], zero_set[p]);
      mode = p / 2;
      send_idle_pct = (mode == 0) ? 34 : ((mode == 1) ? 59 : 0);
      recv_idle_pct = (mode == 0) ? 59 : ((mode == 1) ? 34 : 0);
      for (int i = 0; i < PHASE_REQS; i++)
        drive_random();
    end

    wait_drained();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
src/rto_pkg.sv
src/retriggerable_triangle_oscillator.sv
test/tb.sv
